// ===== rtl/gfrs_pkg.sv =====
// Shared constants, types and controller/datapath interface for the grid Fenwick block.
package gfrs_pkg;

  localparam int GRID_SIDE = 1024;
  localparam int COORD_W   = 10;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(GRID_SIDE + 1);
  localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    REQ_UPDATE,
    REQ_QUERY,
    REQ_CLEAR
  } req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_CELL_RD,
    S_CELL_WR,
    S_U_RD,
    S_U_WR,
    S_Q_START,
    S_Q_RD,
    S_Q_ACC,
    S_Q_NEXT,
    S_Q_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic cell_rd;
    logic cell_wr;
    logic tree_rd;
    logic up_step;
    logic pass_start;
    logic dn_step;
    logic pass_adv;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       in_grid;
    logic       clr_last;
    logic       up_done;
    logic       dn_done;
    logic       pass_empty;
    logic       last_pass;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/gfrs_ctrl.sv =====
// Sequencer for clear sweeps, point updates and four-pass rectangle queries.
module gfrs_ctrl import gfrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.kind)
          REQ_UPDATE: state_nxt = sts.in_grid ? S_CELL_RD : S_IDLE;
          REQ_QUERY:  state_nxt = S_Q_START;
          REQ_CLEAR:  state_nxt = S_CLEAR;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_CELL_RD: state_nxt = S_CELL_WR;
      S_CELL_WR: state_nxt = S_U_RD;
      S_U_RD:    state_nxt = S_U_WR;
      S_U_WR: begin
        state_nxt = sts.up_done ? S_IDLE : S_U_RD;
      end
      S_Q_START: begin
        state_nxt = sts.pass_empty ? S_Q_NEXT : S_Q_RD;
      end
      S_Q_RD:  state_nxt = S_Q_ACC;
      S_Q_ACC: begin
        state_nxt = sts.dn_done ? S_Q_NEXT : S_Q_RD;
      end
      S_Q_NEXT: begin
        state_nxt = sts.last_pass ? S_Q_DONE : S_Q_START;
      end
      S_Q_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR:   cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE:  cmd = '0;
      S_CELL_RD: cmd.cell_rd = 1'b1;
      S_CELL_WR: cmd.cell_wr = 1'b1;
      S_U_RD:    cmd.tree_rd = 1'b1;
      S_U_WR:    cmd.up_step = 1'b1;
      S_Q_START: cmd.pass_start = 1'b1;
      S_Q_RD:    cmd.tree_rd = 1'b1;
      S_Q_ACC:   cmd.dn_step = 1'b1;
      S_Q_NEXT:  cmd.pass_adv = 1'b1;
      S_Q_DONE:  cmd.out_load = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== rtl/gfrs_dp.sv =====
// Datapath: tree and cell memories, walk registers, clamp, accumulator and result register.
module gfrs_dp import gfrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               in_req_type,
  input  logic [COORD_W-1:0]       in_corner_x0,
  input  logic [COORD_W-1:0]       in_corner_y0,
  input  logic [COORD_W-1:0]       in_corner_x1,
  input  logic [COORD_W-1:0]       in_corner_y1,
  input  logic signed [DATA_W-1:0] in_delta,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_rect_sum,
  input  cmd_t                     cmd,
  output sts_t                     sts
);

  localparam logic [IDX_W:0] SIDE_EXT = (IDX_W + 1)'(GRID_SIDE);

  function automatic logic [ADDR_W-1:0] node_addr(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] y);
    node_addr = ADDR_W'(x - 1'b1) * ADDR_W'(GRID_SIDE) + ADDR_W'(y - 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
    if (IDX_W'(v) > IDX_W'(GRID_SIDE - 1)) sat_coord = IDX_W'(GRID_SIDE - 1);
    else sat_coord = IDX_W'(v);
  endfunction

  function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] v);
    low_bit = v & (~v + 1'b1);
  endfunction

  logic [DATA_W-1:0] tree_mem [DEPTH];
  logic [DATA_W-1:0] cell_mem [DEPTH];

  logic [DATA_W-1:0] tree_rd_r;
  logic [DATA_W-1:0] cell_rd_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_sum_r;
  logic [1:0]        pass_r;
  logic [1:0]        kind_r;
  logic              in_grid_r;
  logic [DATA_W-1:0] delta_r;
  logic [DATA_W-1:0] applied_r;
  logic [DATA_W-1:0] acc_r;
  logic [IDX_W-1:0]  hx_r, hy_r, lx_r, ly_r;
  logic [IDX_W-1:0]  x_r, y_r, y0_r;

  logic [IDX_W-1:0]  xa, xb, ya, yb;
  logic [IDX_W-1:0]  load_hx, load_hy;
  logic [IDX_W-1:0]  px, py;
  logic [IDX_W:0]    x_up, y_up;
  logic [IDX_W-1:0]  x_dn, y_dn;
  logic [IDX_W-1:0]  x_nxt, y_nxt;
  logic [ADDR_W-1:0] walk_addr;
  logic [ADDR_W-1:0] cell_addr;
  logic [DATA_W:0]   clamp_sum;
  logic [DATA_W-1:0] applied;
  logic              tree_we, cell_we;
  logic [ADDR_W-1:0] tree_waddr, cell_waddr;
  logic [DATA_W-1:0] tree_wdata, cell_wdata;

  // corners in order, upper edges as one-based indexes
  always_comb begin
    xa = sat_coord(in_corner_x0);
    xb = sat_coord(in_corner_x1);
    ya = sat_coord(in_corner_y0);
    yb = sat_coord(in_corner_y1);
    if (xa > xb) begin
      xa = sat_coord(in_corner_x1);
      xb = sat_coord(in_corner_x0);
    end
    if (ya > yb) begin
      ya = sat_coord(in_corner_y1);
      yb = sat_coord(in_corner_y0);
    end
    if (in_req_type == REQ_UPDATE) begin
      load_hx = IDX_W'(in_corner_x1) + 1'b1;
      load_hy = IDX_W'(in_corner_y1) + 1'b1;
    end else begin
      load_hx = xb + 1'b1;
      load_hy = yb + 1'b1;
    end
  end

  always_comb begin
    case (pass_r)
      2'd0: begin
        px = hx_r;
        py = hy_r;
      end
      2'd1: begin
        px = hx_r;
        py = ly_r;
      end
      2'd2: begin
        px = lx_r;
        py = hy_r;
      end
      default: begin
        px = lx_r;
        py = ly_r;
      end
    endcase
  end

  assign x_up = {1'b0, x_r} + {1'b0, low_bit(x_r)};
  assign y_up = {1'b0, y_r} + {1'b0, low_bit(y_r)};
  assign x_dn = x_r - low_bit(x_r);
  assign y_dn = y_r - low_bit(y_r);

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (cmd.up_step) begin
      if (y_up <= SIDE_EXT) begin
        y_nxt = y_up[IDX_W-1:0];
      end else begin
        x_nxt = x_up[IDX_W-1:0];
        y_nxt = y0_r;
      end
    end else if (cmd.dn_step) begin
      if (y_dn != '0) begin
        y_nxt = y_dn;
      end else begin
        x_nxt = x_dn;
        y_nxt = y0_r;
      end
    end
  end

  assign walk_addr = node_addr(x_r, y_r);
  assign cell_addr = node_addr(hx_r, hy_r);

  // clamp so the cell never drops below zero
  assign clamp_sum = {cell_rd_r[DATA_W-1], cell_rd_r} + {delta_r[DATA_W-1], delta_r};
  assign applied   = clamp_sum[DATA_W] ? ('0 - cell_rd_r) : delta_r;

  assign tree_we    = cmd.clr_step | cmd.up_step;
  assign tree_waddr = cmd.clr_step ? clr_addr_r : walk_addr;
  assign tree_wdata = cmd.clr_step ? '0 : tree_rd_r + applied_r;
  assign cell_we    = cmd.clr_step | cmd.cell_wr;
  assign cell_waddr = cmd.clr_step ? clr_addr_r : cell_addr;
  assign cell_wdata = cmd.clr_step ? '0 : cell_rd_r + applied;

  always_ff @(posedge clk) begin
    if (tree_we) tree_mem[tree_waddr] <= tree_wdata;
    if (cmd.tree_rd) tree_rd_r <= tree_mem[walk_addr];
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    if (cmd.cell_rd) cell_rd_r <= cell_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      pass_r      <= '0;
    end else begin
      if (cmd.load) clr_addr_r <= '0;
      else if (cmd.clr_step) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.load) pass_r <= '0;
      else if (cmd.pass_adv) pass_r <= pass_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_req_type;
      in_grid_r <= (IDX_W'(in_corner_x1) < IDX_W'(GRID_SIDE)) &&
                   (IDX_W'(in_corner_y1) < IDX_W'(GRID_SIDE));
      delta_r   <= in_delta;
      hx_r      <= load_hx;
      hy_r      <= load_hy;
      lx_r      <= xa;
      ly_r      <= ya;
      acc_r     <= '0;
    end
    if (cmd.cell_wr) begin
      applied_r <= applied;
      x_r       <= hx_r;
      y_r       <= hy_r;
      y0_r      <= hy_r;
    end else if (cmd.pass_start) begin
      x_r  <= px;
      y_r  <= py;
      y0_r <= py;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
    if (cmd.dn_step) begin
      if (pass_r[0] ^ pass_r[1]) acc_r <= acc_r - tree_rd_r;
      else acc_r <= acc_r + tree_rd_r;
    end
    if (cmd.out_load) out_sum_r <= acc_r;
  end

  assign sts.kind       = kind_r;
  assign sts.in_grid    = in_grid_r;
  assign sts.clr_last   = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign sts.up_done    = (y_up > SIDE_EXT) && (x_up > SIDE_EXT);
  assign sts.dn_done    = (y_dn == '0) && (x_dn == '0);
  assign sts.pass_empty = (px == '0) || (py == '0);
  assign sts.last_pass  = (pass_r == 2'd3);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_rect_sum = out_sum_r;

endmodule

// ===== rtl/grid_fenwick_rect_sum.sv =====
// Top level of the grid Fenwick rectangle-sum block.
// A GRID_SIDE by GRID_SIDE grid of counts kept as a 2-D binary indexed tree plus a
// plain cell copy, each in a single-port memory with one access per cycle. One
// transaction is handled at a time; a query result waits in an output register
// while the next transaction is taken. Point update: the cell is read and written,
// then each tree node on the upward walk is read and written, Nx and Ny being the
// walk lengths (at most 11 each at GRID_SIDE 1024). Rectangle query: four prefix
// walks, each reading and accumulating the nodes given by the set bits of the walk
// start (Nx and Ny at most 10 each), then the sum goes to the result register.
// Clear: one zeroing pass over all GRID_SIDE*GRID_SIDE entries, writing both
// memories one entry per cycle; the same pass runs after reset, and no input
// transaction is taken until it ends. Updates, clears and unused request codes
// give no result.
module grid_fenwick_rect_sum import gfrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_req_type,
  input  logic [COORD_W-1:0]       in_corner_x0,
  input  logic [COORD_W-1:0]       in_corner_y0,
  input  logic [COORD_W-1:0]       in_corner_x1,
  input  logic [COORD_W-1:0]       in_corner_y1,
  input  logic signed [DATA_W-1:0] in_delta,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_rect_sum
);

  cmd_t cmd;
  sts_t sts;

  gfrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  gfrs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_req_type  (in_req_type),
    .in_corner_x0 (in_corner_x0),
    .in_corner_y0 (in_corner_y0),
    .in_corner_x1 (in_corner_x1),
    .in_corner_y1 (in_corner_y1),
    .in_delta     (in_delta),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rect_sum (out_rect_sum),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// ===== rtl/gfrs_checker.sv =====
// Port-level checks for the grid Fenwick block, bound to the top level.
module gfrs_checker import gfrs_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               in_req_type,
  input logic [COORD_W-1:0]       in_corner_x0,
  input logic [COORD_W-1:0]       in_corner_y0,
  input logic [COORD_W-1:0]       in_corner_x1,
  input logic [COORD_W-1:0]       in_corner_y1,
  input logic signed [DATA_W-1:0] in_delta,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_rect_sum
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rect_sum))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction taken back to back");

  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during clearing pass after reset");

  a_no_result_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type != REQ_QUERY) && !out_valid |=> !out_valid)
    else $error("result produced by a non-query transaction");

endmodule

bind grid_fenwick_rect_sum gfrs_checker u_checker (.*);

// ===== verif/grid_fenwick_rect_sum_tb.sv =====
// Self-checking testbench for grid_fenwick_rect_sum: updates, rectangle queries and clears.
module grid_fenwick_rect_sum_tb import gfrs_pkg::*;;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         HOT_CELLS   = 12;
  localparam int         PHASE_REQS  = 367;
  localparam int         HOLD_CYCLES = 5000;
  localparam int         DRAIN_WAIT  = 1200;
  localparam longint     CYCLE_LIMIT = 12_000_000;

  typedef struct {
    logic [1:0]               req;
    logic [COORD_W-1:0]       x0;
    logic [COORD_W-1:0]       y0;
    logic [COORD_W-1:0]       x1;
    logic [COORD_W-1:0]       y1;
    logic signed [DATA_W-1:0] delta;
  } grid_req_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_req_type = '0;
  logic [COORD_W-1:0]       in_corner_x0 = '0;
  logic [COORD_W-1:0]       in_corner_y0 = '0;
  logic [COORD_W-1:0]       in_corner_x1 = '0;
  logic [COORD_W-1:0]       in_corner_y1 = '0;
  logic signed [DATA_W-1:0] in_delta = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_rect_sum;

  grid_req_t          pending_reqs[$];
  grid_req_t          on_bus;
  logic [DATA_W-1:0]  rect_sums_due[$];
  logic [DATA_W-1:0]  fen_tree[int];
  logic [DATA_W-1:0]  cell_val[int];
  logic [COORD_W-1:0] hot_x[HOT_CELLS];
  logic [COORD_W-1:0] hot_y[HOT_CELLS];

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     error_count = 0;
  int     hold_left = 0;
  bit     hold_request = 1'b0;
  bit     hold_taken = 1'b0;
  longint cycle_count = 0;

  grid_fenwick_rect_sum u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_corner_x0 (in_corner_x0),
    .in_corner_y0 (in_corner_y0),
    .in_corner_x1 (in_corner_x1),
    .in_corner_y1 (in_corner_y1),
    .in_delta     (in_delta),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rect_sum (out_rect_sum)
  );

  always #1 clk = ~clk;

  function automatic logic [DATA_W-1:0] tree_at(int addr);
    return fen_tree.exists(addr) ? fen_tree[addr] : '0;
  endfunction

  function automatic logic [DATA_W-1:0] cell_at(int addr);
    return cell_val.exists(addr) ? cell_val[addr] : '0;
  endfunction

  function automatic logic [DATA_W-1:0] prefix_total(int px, int py);
    logic [DATA_W-1:0] acc;
    int x;
    int y;
    acc = '0;
    for (x = px; x > 0; x -= x & -x)
      for (y = py; y > 0; y -= y & -y)
        acc += tree_at((x - 1) * GRID_SIDE + (y - 1));
    return acc;
  endfunction

  function automatic int clip_coord(logic [COORD_W-1:0] v);
    return (int'(v) > GRID_SIDE - 1) ? GRID_SIDE - 1 : int'(v);
  endfunction

  function automatic void apply_grid_request(grid_req_t r);
    int                addr;
    int                x;
    int                y;
    int                xa;
    int                ya;
    int                xb;
    int                yb;
    int                t;
    longint            cur;
    longint            dl;
    logic [DATA_W-1:0] applied;
    logic [DATA_W-1:0] total;
    case (r.req)
      REQ_UPDATE: begin
        if (int'(r.x1) < GRID_SIDE && int'(r.y1) < GRID_SIDE) begin
          addr = int'(r.x1) * GRID_SIDE + int'(r.y1);
          cur = longint'($signed(cell_at(addr)));
          dl = longint'(r.delta);
          if (cur + dl < 0) applied = DATA_W'(-cur);
          else applied = DATA_W'(dl);
          cell_val[addr] = cell_at(addr) + applied;
          for (x = int'(r.x1) + 1; x <= GRID_SIDE; x += x & -x)
            for (y = int'(r.y1) + 1; y <= GRID_SIDE; y += y & -y)
              fen_tree[(x - 1) * GRID_SIDE + (y - 1)] =
                tree_at((x - 1) * GRID_SIDE + (y - 1)) + applied;
        end
      end
      REQ_QUERY: begin
        xa = clip_coord(r.x0);
        ya = clip_coord(r.y0);
        xb = clip_coord(r.x1);
        yb = clip_coord(r.y1);
        if (xa > xb) begin
          t = xa; xa = xb; xb = t;
        end
        if (ya > yb) begin
          t = ya; ya = yb; yb = t;
        end
        total = prefix_total(xb + 1, yb + 1) - prefix_total(xb + 1, ya)
              - prefix_total(xa, yb + 1) + prefix_total(xa, ya);
        rect_sums_due.push_back(total);
      end
      REQ_CLEAR: begin
        fen_tree.delete();
        cell_val.delete();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void push_req(logic [1:0] req, int x0, int y0, int x1, int y1,
                                   logic [DATA_W-1:0] delta);
    grid_req_t r;
    r.req   = req;
    r.x0    = COORD_W'(x0);
    r.y0    = COORD_W'(y0);
    r.x1    = COORD_W'(x1);
    r.y1    = COORD_W'(y1);
    r.delta = delta;
    pending_reqs.push_back(r);
  endfunction

  function automatic grid_req_t rand_req();
    grid_req_t r;
    int        pick;
    int        h;
    pick    = $urandom_range(99);
    h       = $urandom_range(HOT_CELLS - 1);
    r.x0    = COORD_W'($urandom);
    r.y0    = COORD_W'($urandom);
    r.x1    = COORD_W'($urandom);
    r.y1    = COORD_W'($urandom);
    r.delta = $urandom;
    if (pick < 3) begin
      r.req = REQ_UNUSED;
    end else if (pick < 55) begin
      r.req = REQ_UPDATE;
      if ($urandom_range(1) == 1) begin
        r.x1 = hot_x[h];
        r.y1 = hot_y[h];
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        r.delta = $urandom_range(1000, 1);
      end else if (pick < 65) begin
        r.delta = -int'($urandom_range(2000, 1));
      end else if (pick < 80) begin
        r.delta = $urandom;
      end else if (pick < 90) begin
        r.delta = {1'b1, 31'($urandom)};
      end else begin
        case ($urandom_range(3))
          0: r.delta = 32'h7FFF_FFFF;
          1: r.delta = 32'h8000_0000;
          2: r.delta = 32'h0000_0000;
          default: r.delta = 32'hFFFF_FFFF;
        endcase
      end
    end else begin
      r.req = REQ_QUERY;
      pick = $urandom_range(2);
      if (pick == 0) begin
        r.x0 = hot_x[h];
        r.x1 = hot_x[h];
        r.y0 = hot_y[h];
        r.y1 = hot_y[h];
      end else if (pick == 1) begin
        r.x0 = COORD_W'($urandom_range(hot_x[h]));
        r.x1 = COORD_W'($urandom_range(GRID_SIDE - 1, hot_x[h]));
        r.y0 = COORD_W'($urandom_range(hot_y[h]));
        r.y1 = COORD_W'($urandom_range(GRID_SIDE - 1, hot_y[h]));
        if ($urandom_range(1) == 1) begin
          r.x0 = r.x1;
          r.x1 = COORD_W'($urandom_range(hot_x[h]));
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_grid_request(on_bus);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_reqs.pop_front();
          in_valid     <= 1'b1;
          in_req_type  <= on_bus.req;
          in_corner_x0 <= on_bus.x0;
          in_corner_y0 <= on_bus.y0;
          in_corner_x1 <= on_bus.x1;
          in_corner_y1 <= on_bus.y1;
          in_delta     <= on_bus.delta;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rect_sums_due.size() == 0) begin
          $display("%0t: unexpected rect_sum transaction, expected none, actual %0d",
                   $time, out_rect_sum);
          error_count++;
        end else if (out_rect_sum !== rect_sums_due[0]) begin
          $display("%0t: rect_sum mismatch, expected %0d, actual %0d",
                   $time, $signed(rect_sums_due[0]), out_rect_sum);
          error_count++;
          void'(rect_sums_due.pop_front());
        end else begin
          void'(rect_sums_due.pop_front());
        end
      end
      if (hold_request && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_ready  <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int n;
    grid_req_t r;
    hot_x[0] = '0;
    hot_y[0] = '0;
    hot_x[1] = COORD_W'(GRID_SIDE - 1);
    hot_y[1] = COORD_W'(GRID_SIDE - 1);
    hot_x[2] = '0;
    hot_y[2] = COORD_W'(GRID_SIDE - 1);
    for (int i = 3; i < HOT_CELLS; i++) begin
      hot_x[i] = COORD_W'($urandom);
      hot_y[i] = COORD_W'($urandom);
    end

    push_req(REQ_QUERY, 0, 0, 1023, 1023, 32'h0);
    push_req(REQ_UPDATE, 0, 0, 0, 0, 32'd5);
    push_req(REQ_UPDATE, 0, 0, 1023, 1023, 32'h7FFF_FFFF);
    push_req(REQ_UPDATE, 0, 0, 1023, 1023, 32'd1);
    push_req(REQ_QUERY, 1023, 1023, 1023, 1023, 32'h0);
    push_req(REQ_UPDATE, 0, 0, 1023, 1023, 32'hFFFF_FFFF);
    push_req(REQ_UPDATE, 0, 0, 0, 0, -32'sd7);
    push_req(REQ_UPDATE, 0, 0, 512, 300, 32'd100);
    push_req(REQ_UPDATE, 0, 0, 511, 1023, 32'h8000_0000);
    push_req(REQ_QUERY, 1023, 1023, 0, 0, 32'h0);
    push_req(REQ_QUERY, 600, 400, 500, 200, 32'hFFFF_FFFF);
    push_req(REQ_UNUSED, 1023, 1023, 1023, 1023, 32'hFFFF_FFFF);
    push_req(REQ_QUERY, 0, 0, 511, 299, 32'h0);
    push_req(REQ_UPDATE, 0, 0, 5, 7, 32'h7FFF_FFFF);
    push_req(REQ_UPDATE, 0, 0, 6, 7, 32'h7FFF_FFFF);
    push_req(REQ_QUERY, 4, 0, 6, 1023, 32'h0);
    push_req(REQ_CLEAR, 1023, 1023, 1023, 1023, 32'hFFFF_FFFF);
    push_req(REQ_QUERY, 0, 0, 1023, 1023, 32'h0);
    push_req(REQ_UPDATE, 0, 0, 1023, 0, 32'd123);
    push_req(REQ_UPDATE, 0, 0, 0, 1023, 32'd456);
    push_req(REQ_QUERY, 0, 1023, 1023, 0, 32'h0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk);
      send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 7 : 0;
      if (phase == 2) hold_request = 1'b1;
      n = 0;
      while (n < PHASE_REQS) begin
        r = rand_req();
        if (r.req != REQ_UNUSED) n++;
        pending_reqs.push_back(r);
      end
      while (pending_reqs.size() != 0 || in_valid) @(negedge clk);
    end

    while (rect_sums_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== grid_fenwick_rect_sum.f =====
rtl/gfrs_pkg.sv
rtl/gfrs_ctrl.sv
rtl/gfrs_dp.sv
rtl/grid_fenwick_rect_sum.sv
rtl/gfrs_checker.sv
verif/grid_fenwick_rect_sum_tb.sv
